// ----- rtl/gcd_pkg.sv -----
// Shared constants, status codes and the controller command type for the change dispenser.
package gcd_pkg;

  // Default widths of stock counts and cent amounts
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int AMOUNT_WIDTH_DEF = 20;

  // Width of the reported till value (taken modulo its range)
  localparam int TILL_WIDTH = 27;

  // Denominations, largest first
  localparam int NUM_DENOMS = 7;
  localparam int DENOM_W    = 10;
  localparam int IDX_W      = 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOMS - 1);

  localparam logic [DENOM_W-1:0] DENOM_CENTS [NUM_DENOMS] = '{
    10'd1000, 10'd500, 10'd200, 10'd50, 10'd25, 10'd10, 10'd5
  };

  // Opcodes on the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SALE = 1'b1;

  // Result status codes on the output tuser
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_LOADED       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PAY_SHORT    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CHANGE_SHORT = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             accept;      // latch input word
    logic             step_mul;    // left times reciprocal, stock times denomination
    logic             step_quo;    // estimate quotient and its product
    logic             step_take;   // correct quotient, take coins, update stock
    logic             till_mul;    // multiply one stock count by its denomination
    logic             till_add;    // accumulate the last product
    logic             out_load;    // move result into the output register
    logic [IDX_W-1:0] idx;         // denomination being worked on
  } cmd_t;

endpackage

// ----- rtl/gcd_ctrl.sv -----
// Controller state machine for the change dispenser: sequences sale steps and the till pass.
module gcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          opcode,
  output logic          m_tvalid,
  input  logic          m_tready,
  output gcd_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MUL       = 3'd1;
  localparam logic [2:0] ST_QUO       = 3'd2;
  localparam logic [2:0] ST_TAKE      = 3'd3;
  localparam logic [2:0] ST_TILL_MUL  = 3'd4;
  localparam logic [2:0] ST_TILL_LAST = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [gcd_pkg::IDX_W-1:0]  idx;
  logic [gcd_pkg::IDX_W-1:0]  idx_next;
  logic                       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Decode state into commands and next state
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd          = '0;
    cmd.idx      = idx;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          idx_next   = '0;
          state_next = (opcode == gcd_pkg::OP_SALE) ? ST_MUL : ST_TILL_MUL;
        end
      end
      ST_MUL: begin
        cmd.step_mul = 1'b1;
        state_next   = ST_QUO;
      end
      ST_QUO: begin
        cmd.step_quo = 1'b1;
        state_next   = ST_TAKE;
      end
      ST_TAKE: begin
        cmd.step_take = 1'b1;
        if (idx == gcd_pkg::LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_TILL_MUL;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_TILL_MUL: begin
        cmd.till_mul = 1'b1;
        cmd.till_add = (idx != '0);
        if (idx == gcd_pkg::LAST_IDX) begin
          state_next = ST_TILL_LAST;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_TILL_LAST: begin
        cmd.till_add = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state and hold output valid until the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/gcd_datapath.sv -----
// Datapath of the change dispenser: stock counts, greedy change arithmetic, till sum, result register.
module gcd_datapath #(
  parameter int COUNT_WIDTH  = gcd_pkg::COUNT_WIDTH_DEF,
  parameter int AMOUNT_WIDTH = gcd_pkg::AMOUNT_WIDTH_DEF,
  parameter int IN_W         = 152,
  parameter int OUT_W        = 184
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gcd_pkg::cmd_t                 cmd,
  input  logic [IN_W-1:0]               s_tdata,
  input  logic                          s_tuser,
  output logic [OUT_W-1:0]              m_tdata,
  output logic [gcd_pkg::STATUS_W-1:0]  m_tuser
);

  localparam int CW    = COUNT_WIDTH;
  localparam int AW    = AMOUNT_WIDTH;
  localparam int ND    = gcd_pkg::NUM_DENOMS;
  localparam int TW    = gcd_pkg::TILL_WIDTH;
  localparam int CMP_W = (AW > CW) ? AW : CW;
  localparam int GAVE_LO = 2 * AW;
  localparam int TILL_LO = 2 * AW + ND * CW;

  // Floor of 2^AW over each denomination; the quotient estimate is low by at most one
  localparam logic [AW:0] POW2 = {1'b1, {AW{1'b0}}};
  localparam logic [AW-1:0] RECIP [ND] = '{
    AW'(POW2 / gcd_pkg::DENOM_CENTS[0]), AW'(POW2 / gcd_pkg::DENOM_CENTS[1]),
    AW'(POW2 / gcd_pkg::DENOM_CENTS[2]), AW'(POW2 / gcd_pkg::DENOM_CENTS[3]),
    AW'(POW2 / gcd_pkg::DENOM_CENTS[4]), AW'(POW2 / gcd_pkg::DENOM_CENTS[5]),
    AW'(POW2 / gcd_pkg::DENOM_CENTS[6])
  };

  // Item state
  logic [CW-1:0]   stock [ND];
  logic [CW-1:0]   gave  [ND];
  logic            is_sale;
  logic            pay_short;
  logic [AW-1:0]   due;
  logic [AW-1:0]   left;

  // Per-denomination pipeline registers
  logic [2*AW-1:0] prod_q;
  logic [AW-1:0]   stock_d;
  logic [AW-1:0]   q0;
  logic [AW-1:0]   qd;

  // Till pass
  logic [TW-1:0]   till_prod;
  logic [TW-1:0]   till_acc;

  // Output register
  logic [gcd_pkg::STATUS_W-1:0] out_status;
  logic [AW-1:0]   out_due;
  logic [AW-1:0]   out_left;
  logic [CW-1:0]   out_gave [ND];
  logic [TW-1:0]   out_till;

  // Combinational helpers
  logic [AW:0]     diff;
  logic [AW-1:0]   denom_aw;
  logic [CW-1:0]   stock_sel;
  logic [AW-1:0]   rem_raw;
  logic [AW-1:0]   rem;
  logic [AW-1:0]   want;
  logic            fits;
  logic [CW-1:0]   take;
  logic [AW-1:0]   left_new;

  assign diff      = {1'b0, s_tdata[2*AW-1:AW]} - {1'b0, s_tdata[AW-1:0]};
  assign denom_aw  = AW'(gcd_pkg::DENOM_CENTS[cmd.idx]);
  assign stock_sel = stock[cmd.idx];

  // Correct the quotient estimate, then limit it by the stock on hand
  always_comb begin
    rem_raw = left - qd;
    if (rem_raw >= denom_aw) begin
      want = q0 + 1'b1;
      rem  = rem_raw - denom_aw;
    end else begin
      want = q0;
      rem  = rem_raw;
    end
    fits     = CMP_W'(want) <= CMP_W'(stock_sel);
    take     = fits ? CW'(want) : stock_sel;
    left_new = fits ? rem : (left - stock_d);
  end

  // Stock counts: set by a load, reduced as change is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ND; k++) begin
        stock[k] <= '0;
      end
    end else if (cmd.accept && (s_tuser == gcd_pkg::OP_LOAD)) begin
      for (int k = 0; k < ND; k++) begin
        stock[k] <= s_tdata[2*AW + k*CW +: CW];
      end
    end else if (cmd.step_take) begin
      stock[cmd.idx] <= stock_sel - take;
    end
  end

  // Item registers and greedy arithmetic; a load or a short payment owes no change
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_sale   <= (s_tuser == gcd_pkg::OP_SALE);
      pay_short <= diff[AW];
      due       <= (diff[AW] || (s_tuser == gcd_pkg::OP_LOAD)) ? '0 : diff[AW-1:0];
      left      <= (diff[AW] || (s_tuser == gcd_pkg::OP_LOAD)) ? '0 : diff[AW-1:0];
      for (int k = 0; k < ND; k++) begin
        gave[k] <= '0;
      end
    end
    if (cmd.step_mul) begin
      prod_q  <= (2*AW)'(left) * (2*AW)'(RECIP[cmd.idx]);
      stock_d <= AW'(stock_sel) * denom_aw;
    end
    if (cmd.step_quo) begin
      q0 <= prod_q[2*AW-1:AW];
      qd <= AW'(prod_q[2*AW-1:AW] * denom_aw);
    end
    if (cmd.step_take) begin
      gave[cmd.idx] <= take;
      left          <= left_new;
    end
  end

  // Till sum: one product per cycle, each accumulated in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      till_acc <= '0;
    end else if (cmd.till_add) begin
      till_acc <= till_acc + till_prod;
    end
    if (cmd.till_mul) begin
      till_prod <= TW'(stock_sel) * TW'(gcd_pkg::DENOM_CENTS[cmd.idx]);
    end
  end

  // Capture the finished result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!is_sale) begin
        out_status <= gcd_pkg::STATUS_LOADED;
      end else if (pay_short) begin
        out_status <= gcd_pkg::STATUS_PAY_SHORT;
      end else if (left == '0) begin
        out_status <= gcd_pkg::STATUS_FULL;
      end else begin
        out_status <= gcd_pkg::STATUS_CHANGE_SHORT;
      end
      out_due  <= due;
      out_left <= left;
      out_till <= till_acc;
      for (int k = 0; k < ND; k++) begin
        out_gave[k] <= gave[k];
      end
    end
  end

  // Pack the output word
  always_comb begin
    m_tdata                    = '0;
    m_tdata[AW-1:0]            = out_due;
    m_tdata[2*AW-1:AW]         = out_left;
    for (int k = 0; k < ND; k++) begin
      m_tdata[GAVE_LO + k*CW +: CW] = out_gave[k];
    end
    m_tdata[TILL_LO +: TW]     = out_till;
  end

  assign m_tuser = out_status;

endmodule

// ----- rtl/greedy_change_dispenser.sv -----
// Top level of the change dispenser: stream ports, controller and datapath.
//
// Keeps stock for 1000, 500, 200, 50, 25, 10 and 5 cent units and answers every input word
// with one output word. A load latches the counts, forms the till sum (one shared multiplier,
// one denomination per cycle, plus a final add) and then loads the output register. A sale
// runs the greedy pass over each of the seven denominations in turn (quotient estimate by a
// reciprocal multiply, product back-multiply, then correct and take from stock), followed by
// the same till pass. One item is worked on at a time; the next input word is accepted as soon
// as the result is in the output register, even while that result still waits to be taken.
module greedy_change_dispenser #(
  parameter int COUNT_WIDTH  = gcd_pkg::COUNT_WIDTH_DEF,
  parameter int AMOUNT_WIDTH = gcd_pkg::AMOUNT_WIDTH_DEF,
  parameter int IN_W  = ((2*AMOUNT_WIDTH + gcd_pkg::NUM_DENOMS*COUNT_WIDTH + 7) / 8) * 8,
  parameter int OUT_W = ((2*AMOUNT_WIDTH + gcd_pkg::NUM_DENOMS*COUNT_WIDTH
                          + gcd_pkg::TILL_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // price_cents, paid_cents, load_count_1000, load_count_500, load_count_200,
  // load_count_50, load_count_25, load_count_10, load_count_5
  input  logic [IN_W-1:0]              s_tdata,
  // opcode
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // change_due_cents, unpaid_remainder_cents, gave_1000, gave_500, gave_200,
  // gave_50, gave_25, gave_10, gave_5, till_value_cents
  output logic [OUT_W-1:0]             m_tdata,
  // status
  output logic [gcd_pkg::STATUS_W-1:0] m_tuser
);

  gcd_pkg::cmd_t cmd;

  gcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gcd_datapath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .AMOUNT_WIDTH (AMOUNT_WIDTH),
    .IN_W         (IN_W),
    .OUT_W        (OUT_W)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
